// ----- hw/rtl/ljpf_pkg.sv -----
// ----------------------------------------------------------------------------
// ljpf_pkg
// Shared types, register codes, constants and multiply helpers for the
// Lennard-Jones pair force pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ljpf_pkg;

  localparam int NSTG     = 29;
  localparam int DIV_BITS = 37;
  localparam int DIV_PER  = 4;
  localparam int DIV_N    = (DIV_BITS + DIV_PER - 1) / DIV_PER;
  localparam int SD_N     = 22;

  typedef enum logic [7:0] {
    REG_BOX          = 8'd0,
    REG_INV_BOX      = 8'd1,
    REG_CUTOFF_SQ    = 8'd2,
    REG_ENERGY_SHIFT = 8'd3
  } reg_idx_t;

  localparam logic signed [47:0] Q48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q48_MIN = 48'sh8000_0000_0000;

  localparam logic [30:0]        BOX_RST   = 31'd167772160;
  localparam logic [30:0]        INV_RST   = 31'd1677722;
  localparam logic [30:0]        CUT_RST   = 31'd104857600;
  localparam logic signed [31:0] SHIFT_RST = -32'sd273750;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
  } pair_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic signed [47:0] pair_energy;
    logic signed [47:0] pair_virial;
    logic               in_range;
    logic               overflow;
  } res_t;

  typedef struct packed {
    logic [63:0] hh;
    logic [60:0] hl;
    logic [60:0] lh;
    logic [57:0] ll;
  } pp_t;

  typedef struct packed {
    logic [2:0][31:0] w;
    logic             inr;
    logic             ovf;
    logic             ovl;
  } sd_t;

  function automatic pp_t pp_f(input logic [60:0] a, input logic [60:0] b);
    pp_t p;
    p.hh = a[60:29] * b[60:29];
    p.hl = a[60:29] * b[28:0];
    p.lh = a[28:0] * b[60:29];
    p.ll = a[28:0] * b[28:0];
    return p;
  endfunction

  function automatic logic [63:0] sum_f(input pp_t p);
    logic [95:0] acc;
    acc = (96'(p.hh) << 58) + (96'(p.hl) << 29) + (96'(p.lh) << 29) + 96'(p.ll);
    return acc[95:32];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lj_pair_force_min_image.sv -----
// ----------------------------------------------------------------------------
// lj_pair_force_min_image
// Minimum-image Lennard-Jones pair force, energy and virial, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one particle pair per clock; busy never rises. Each result appears on
// out_result with out_strobe for one cycle; there is no stall. The pipeline
// depth is set by the 37-step reciprocal divider (ten stages of up to four
// steps) and the chain of split multiplications that form r^-6, r^-8, r^-12
// and r^-14. Configuration writes are always ready; each register is read
// at the stage that uses it, so a write also reaches pairs already in flight.
`default_nettype none

module lj_pair_force_min_image (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire ljpf_pkg::pair_t in_pair,
  output logic                out_strobe,
  output ljpf_pkg::res_t      out_result,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [7:0]     cfg_index,
  input  wire logic [31:0]    cfg_data
);
  import ljpf_pkg::*;

  logic [30:0]        box_r, inv_r, cut_r;
  logic signed [31:0] es_r;
  logic [NSTG:1]      vld_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= BOX_RST;
      inv_r <= INV_RST;
      cut_r <= CUT_RST;
      es_r  <= SHIFT_RST;
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-1:1], start & ~busy};
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BOX:          box_r <= cfg_data[30:0];
          REG_INV_BOX:      inv_r <= cfg_data[30:0];
          REG_CUTOFF_SQ:    cut_r <= cfg_data[30:0];
          REG_ENERGY_SHIFT: es_r  <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // displacement and wrap
  logic signed [32:0] d1_r [3];
  logic signed [32:0] d2_r [3];
  logic signed [32:0] d3_r [3];
  logic [63:0]        p2_r [3];
  logic [46:0]        span3_r [3];
  logic [2:0][31:0]   w4_r, w5_r, w6_r;
  logic               cov4_r, cov5_r, cov6_r;
  logic [62:0]        sq5_r [3];
  logic [63:0]        r2_6_r;
  logic [2:0][31:0]   w4_nxt;
  logic               cov4_nxt;

  always_comb begin
    logic signed [48:0] dx, sx, wv;
    cov4_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dx = 49'(d3_r[k]);
      sx = $signed({2'b00, span3_r[k]});
      wv = dx[48] ? dx + sx : dx - sx;
      if (wv > 49'sd2147483647) begin
        w4_nxt[k] = 32'h7FFF_FFFF;
        cov4_nxt  = 1'b1;
      end else if (wv < -49'sd2147483648) begin
        w4_nxt[k] = 32'h8000_0000;
        cov4_nxt  = 1'b1;
      end else begin
        w4_nxt[k] = wv[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [32:0] mag;
    logic [63:0] nsum;
    logic [31:0] wm;
    d1_r[0] <= {in_pair.pos_b_x[31], in_pair.pos_b_x} - {in_pair.pos_a_x[31], in_pair.pos_a_x};
    d1_r[1] <= {in_pair.pos_b_y[31], in_pair.pos_b_y} - {in_pair.pos_a_y[31], in_pair.pos_a_y};
    d1_r[2] <= {in_pair.pos_b_z[31], in_pair.pos_b_z} - {in_pair.pos_a_z[31], in_pair.pos_a_z};
    for (int k = 0; k < 3; k++) begin
      mag        = d1_r[k][32] ? 33'(-d1_r[k]) : 33'(d1_r[k]);
      p2_r[k]    <= 64'(mag) * 64'(inv_r);
      d2_r[k]    <= d1_r[k];
      nsum       = p2_r[k] + 64'h0000_8000_0000_0000;
      span3_r[k] <= 47'(nsum[63:48]) * 47'(box_r);
      d3_r[k]    <= d2_r[k];
      wm         = w4_r[k][31] ? 32'(-w4_r[k]) : w4_r[k];
      sq5_r[k]   <= 63'(64'(wm) * 64'(wm));
    end
    w4_r   <= w4_nxt;
    cov4_r <= cov4_nxt;
    w5_r   <= w4_r;
    cov5_r <= cov4_r;
    r2_6_r <= 64'(sq5_r[0]) + 64'(sq5_r[1]) + 64'(sq5_r[2]);
    w6_r   <= w5_r;
    cov6_r <= cov5_r;
  end

  // range test, side line and reciprocal
  sd_t         sd_r [SD_N];
  logic [38:0] dv_t_r [DIV_N+1];
  logic [39:0] dv_rem_r [DIV_N+1];
  logic [36:0] dv_q_r [DIV_N+1];
  sd_t         sd_nxt;

  always_comb begin
    sd_nxt.w   = w6_r;
    sd_nxt.inr = r2_6_r < {9'b0, cut_r, 24'b0};
    sd_nxt.ovf = cov6_r | (r2_6_r == 64'd0);
    sd_nxt.ovl = sd_nxt.inr & (r2_6_r < 64'h0000_1000_0000_0000);
  end

  always_ff @(posedge clk) begin
    sd_r[0]     <= sd_nxt;
    for (int i = 1; i < SD_N; i++) sd_r[i] <= sd_r[i-1];
    dv_t_r[0]   <= r2_6_r[54:16];
    dv_rem_r[0] <= 40'h00_0800_0000;
    dv_q_r[0]   <= '0;
  end

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    logic [39:0] rem_c;
    logic [36:0] q_c;
    always_comb begin
      rem_c = dv_rem_r[j];
      q_c   = dv_q_r[j];
      for (int k = 0; k < DIV_PER; k++) begin
        if (j * DIV_PER + k < DIV_BITS) begin
          rem_c = {rem_c[38:0], 1'b0};
          if (rem_c >= 40'(dv_t_r[j])) begin
            rem_c = rem_c - 40'(dv_t_r[j]);
            q_c   = {q_c[35:0], 1'b1};
          end else begin
            q_c   = {q_c[35:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      dv_rem_r[j+1] <= rem_c;
      dv_q_r[j+1]   <= q_c;
      dv_t_r[j+1]   <= dv_t_r[j];
    end
  end

  // powers of 1/r^2
  logic [36:0] s18_r, s19_r, s20_r, s21_r, s22_r, s23_r;
  pp_t         pp18_r, pp20a_r, pp20b_r, pp22_r, pp24_r;
  logic [40:0] s2_19_r;
  logic [44:0] s3_21_r, s3_22_r, s3_23_r, s3_24_r, s3_25_r;
  logic [48:0] s4_21_r, s4_22_r, s4_23_r, s4_24_r, s4_25_r;
  logic [56:0] s6_23_r, s6_24_r, s6_25_r;
  logic [60:0] s7_25_r;

  always_ff @(posedge clk) begin
    s18_r   <= dv_q_r[DIV_N];
    pp18_r  <= pp_f(61'(dv_q_r[DIV_N]), 61'(dv_q_r[DIV_N]));
    s19_r   <= s18_r;
    s2_19_r <= 41'(sum_f(pp18_r));
    s20_r   <= s19_r;
    pp20a_r <= pp_f(61'(s2_19_r), 61'(s19_r));
    pp20b_r <= pp_f(61'(s2_19_r), 61'(s2_19_r));
    s21_r   <= s20_r;
    s3_21_r <= 45'(sum_f(pp20a_r));
    s4_21_r <= 49'(sum_f(pp20b_r));
    s22_r   <= s21_r;
    s3_22_r <= s3_21_r;
    s4_22_r <= s4_21_r;
    pp22_r  <= pp_f(61'(s3_21_r), 61'(s3_21_r));
    s23_r   <= s22_r;
    s3_23_r <= s3_22_r;
    s4_23_r <= s4_22_r;
    s6_23_r <= 57'(sum_f(pp22_r));
    s3_24_r <= s3_23_r;
    s4_24_r <= s4_23_r;
    s6_24_r <= s6_23_r;
    pp24_r  <= pp_f(61'(s6_23_r), 61'(s23_r));
    s3_25_r <= s3_24_r;
    s4_25_r <= s4_24_r;
    s6_25_r <= s6_24_r;
    s7_25_r <= 61'(sum_f(pp24_r));
  end

  // energy, virial, force scale
  logic signed [63:0] e26_r, v26_r;
  logic [60:0]        gm26_r;
  logic               gneg26_r, gz26_r;

  always_ff @(posedge clk) begin
    logic signed [63:0] ed, vd, gd;
    ed       = $signed(64'(s6_25_r)) - $signed(64'(s3_25_r));
    e26_r    <= ((ed <<< 2) >>> 8) + 64'(es_r);
    vd       = $signed(64'(s6_25_r) << 1) - $signed(64'(s3_25_r));
    v26_r    <= ((vd <<< 4) + (vd <<< 3)) >>> 8;
    gd       = $signed(64'(s7_25_r) << 1) - $signed(64'(s4_25_r));
    gneg26_r <= gd[63];
    gz26_r   <= gd == 64'sd0;
    gm26_r   <= 61'(gd[63] ? -gd : gd);
  end

  pp_t                fpp27_r [3];
  logic [2:0]         fneg27_r, fz27_r, fneg28_r, fz28_r;
  logic signed [47:0] e27_r, v27_r, e28_r, v28_r;
  logic               esat27_r, vsat27_r, sat28_r;
  logic [63:0]        m28_r [3];

  always_ff @(posedge clk) begin
    logic [31:0] wv;
    logic [31:0] wm;
    for (int k = 0; k < 3; k++) begin
      wv          = sd_r[19].w[k];
      wm          = wv[31] ? 32'(-wv) : wv;
      fpp27_r[k]  <= pp_f(61'(wm), gm26_r);
      fneg27_r[k] <= wv[31] ^ gneg26_r;
      fz27_r[k]   <= (wv == 32'd0) | gz26_r;
      m28_r[k]    <= sum_f(fpp27_r[k]);
    end
    if (e26_r > 64'(Q48_MAX)) begin
      e27_r <= Q48_MAX; esat27_r <= 1'b1;
    end else if (e26_r < 64'(Q48_MIN)) begin
      e27_r <= Q48_MIN; esat27_r <= 1'b1;
    end else begin
      e27_r <= e26_r[47:0]; esat27_r <= 1'b0;
    end
    if (v26_r > 64'(Q48_MAX)) begin
      v27_r <= Q48_MAX; vsat27_r <= 1'b1;
    end else if (v26_r < 64'(Q48_MIN)) begin
      v27_r <= Q48_MIN; vsat27_r <= 1'b1;
    end else begin
      v27_r <= v26_r[47:0]; vsat27_r <= 1'b0;
    end
    fneg28_r <= fneg27_r;
    fz28_r   <= fz27_r;
    e28_r    <= e27_r;
    v28_r    <= v27_r;
    sat28_r  <= esat27_r | vsat27_r;
  end

  // select and saturate
  res_t res_r, res_nxt;

  always_comb begin
    logic [47:0]        mc;
    logic [52:0]        m24;
    logic signed [47:0] f [3];
    logic               fsat;
    logic [31:0]        wv;
    fsat = 1'b0;
    wv   = '0;
    for (int k = 0; k < 3; k++) begin
      mc  = (m28_r[k] > 64'h0000_8000_0000_0000) ? 48'h8000_0000_0000 : m28_r[k][47:0];
      m24 = (53'(mc) << 4) + (53'(mc) << 3);
      if (fz28_r[k]) begin
        f[k] = '0;
      end else if (!fneg28_r[k]) begin
        if (m24 > 53'(Q48_MAX)) begin
          f[k] = Q48_MAX; fsat = 1'b1;
        end else begin
          f[k] = m24[47:0];
        end
      end else begin
        if (m24 > 53'h0_8000_0000_0000) begin
          f[k] = Q48_MIN; fsat = 1'b1;
        end else begin
          f[k] = 48'(-m24);
        end
      end
    end
    res_nxt.in_range = sd_r[21].inr;
    res_nxt.overflow = sd_r[21].ovf;
    if (!sd_r[21].inr) begin
      res_nxt.force_x     = '0;
      res_nxt.force_y     = '0;
      res_nxt.force_z     = '0;
      res_nxt.pair_energy = '0;
      res_nxt.pair_virial = '0;
    end else if (sd_r[21].ovl) begin
      for (int k = 0; k < 3; k++) begin
        wv   = sd_r[21].w[k];
        f[k] = wv[31] ? Q48_MIN : ((wv == 32'd0) ? 48'sd0 : Q48_MAX);
      end
      res_nxt.force_x     = f[0];
      res_nxt.force_y     = f[1];
      res_nxt.force_z     = f[2];
      res_nxt.pair_energy = Q48_MAX;
      res_nxt.pair_virial = Q48_MAX;
      res_nxt.overflow    = 1'b1;
    end else begin
      res_nxt.force_x     = f[0];
      res_nxt.force_y     = f[1];
      res_nxt.force_z     = f[2];
      res_nxt.pair_energy = e28_r;
      res_nxt.pair_virial = v28_r;
      res_nxt.overflow    = sd_r[21].ovf | sat28_r | fsat;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_strobe = vld_r[NSTG];
  assign out_result = res_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ljpf_chk.sv -----
// ----------------------------------------------------------------------------
// ljpf_chk
// Port-level checks for the pair force pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ljpf_chk (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            start,
  input wire logic            busy,
  input wire ljpf_pkg::pair_t in_pair,
  input wire logic            out_strobe,
  input wire ljpf_pkg::res_t  out_result,
  input wire logic            cfg_valid,
  input wire logic            cfg_ready,
  input wire logic [7:0]      cfg_index,
  input wire logic [31:0]     cfg_data
);
  import ljpf_pkg::*;

  logic [4:0] age_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r <= '0;
    end else if (age_r < 5'(NSTG)) begin
      age_r <= age_r + 5'd1;
    end
  end

  a_strobe_follows_start: assert property (@(posedge clk)
    disable iff (!rst_n) out_strobe |-> $past(start && !busy, NSTG))
    else $error("result without a matching transfer");

  a_start_gives_strobe: assert property (@(posedge clk)
    disable iff (!rst_n || age_r < 5'(NSTG)) $past(start && !busy, NSTG) |-> out_strobe)
    else $error("transfer lost");

  a_out_of_range_zero: assert property (@(posedge clk)
    disable iff (!rst_n) out_strobe && !out_result.in_range |->
      out_result.force_x == 48'sd0 && out_result.force_y == 48'sd0 &&
      out_result.force_z == 48'sd0 && out_result.pair_energy == 48'sd0 &&
      out_result.pair_virial == 48'sd0)
    else $error("nonzero result beyond cutoff");

  a_energy_floor: assert property (@(posedge clk)
    disable iff (!rst_n) out_strobe && out_result.in_range |->
      out_result.pair_energy != Q48_MIN)
    else $error("energy hit negative limit");

endmodule

bind lj_pair_force_min_image ljpf_chk u_ljpf_chk (.*);

`default_nettype wire

// ----- tb/sv/tb_lj_pair_force_min_image.sv -----
// ----------------------------------------------------------------------------
// tb_lj_pair_force_min_image
// Self-checking bench for the minimum-image Lennard-Jones pair force pipeline.
// ----------------------------------------------------------------------------
// Drives particle pairs through the start/busy port and checks each strobed
// result, field by field, against a bit-exact predictor of the wrap, cutoff,
// reciprocal power chain and saturation. Several register settings are run,
// from reset values to extremes, with directed corner pairs, well-formed
// near-neighbour pairs, overlapping pairs, whole-box offsets and raw noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lj_pair_force_min_image;
  import ljpf_pkg::*;

  localparam int        WATCHDOG_LIMIT = 5000;
  localparam int        DRAIN_CYCLES   = 40;
  localparam logic [7:0] REG_SPARE     = 8'd4;
  localparam longint    ONE_Q24        = 64'sd16777216;

  class force_scoreboard;
    logic [30:0]        box;
    logic [30:0]        inv_box;
    logic [30:0]        cut_sq;
    logic signed [31:0] e_shift;
    res_t               expected_q[$];
    int                 mismatches;
    int                 checked;
    int                 pairs_seen;
    int                 hits_in_range;
    int                 hits_overflow;

    function new();
      box = BOX_RST;
      inv_box = INV_RST;
      cut_sq = CUT_RST;
      e_shift = SHIFT_RST;
      mismatches = 0;
      checked = 0;
      pairs_seen = 0;
      hits_in_range = 0;
      hits_overflow = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      case (idx)
        REG_BOX: begin
          box = data[30:0];
        end
        REG_INV_BOX: begin
          inv_box = data[30:0];
        end
        REG_CUTOFF_SQ: begin
          cut_sq = data[30:0];
        end
        REG_ENERGY_SHIFT: begin
          e_shift = data;
        end
        default: begin
        end
      endcase
    endfunction

    function logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
      logic [127:0] pr;
      pr = ({64'd0, a} * {64'd0, b}) >> 32;
      return (pr[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : pr[63:0];
    endfunction

    function longint wrap_axis(longint d, ref bit ovf);
      logic [63:0] mag;
      logic [63:0] n;
      longint      span;
      longint      w;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      n = (mag * 64'(inv_box) + (64'd1 << 47)) >> 48;
      span = longint'(n * 64'(box));
      w = (d < 0) ? d + span : d - span;
      if (w > 64'sh7FFF_FFFF) begin
        ovf = 1'b1;
        return 64'sh7FFF_FFFF;
      end
      if (w < -64'sh8000_0000) begin
        ovf = 1'b1;
        return -64'sh8000_0000;
      end
      return w;
    endfunction

    function longint axis_force(longint w, longint g, ref bit ovf);
      logic [63:0] wm;
      logic [63:0] gm;
      logic [63:0] m;
      bit          neg;
      if (w == 0 || g == 0) return 0;
      wm = (w < 0) ? 64'(-w) : 64'(w);
      gm = (g < 0) ? 64'(-g) : 64'(g);
      neg = (w < 0) != (g < 0);
      m = mul_q32(wm, gm);
      if (m > (64'd1 << 47)) m = 64'd1 << 47;
      m = m * 24;
      if (!neg) begin
        if (m > 64'h7FFF_FFFF_FFFF) begin
          ovf = 1'b1;
          return longint'(Q48_MAX);
        end
        return longint'(m);
      end
      if (m > (64'd1 << 47)) begin
        ovf = 1'b1;
        return longint'(Q48_MIN);
      end
      return -longint'(m);
    endfunction

    function longint sat48(longint v, ref bit ovf);
      if (v > longint'(Q48_MAX)) begin
        ovf = 1'b1;
        return longint'(Q48_MAX);
      end
      if (v < longint'(Q48_MIN)) begin
        ovf = 1'b1;
        return longint'(Q48_MIN);
      end
      return v;
    endfunction

    function res_t pair_force(pair_t p);
      res_t        r;
      bit          ovf;
      bit          inr;
      longint      w[3];
      longint      f[3];
      longint      a[3];
      longint      b[3];
      longint      energy;
      longint      virial;
      longint      g;
      logic [63:0] r2;
      logic [63:0] s, s2, s3, s4, s6, s7;
      logic [127:0] q;
      ovf = 1'b0;
      energy = 0;
      virial = 0;
      r2 = 0;
      a[0] = p.pos_a_x; a[1] = p.pos_a_y; a[2] = p.pos_a_z;
      b[0] = p.pos_b_x; b[1] = p.pos_b_y; b[2] = p.pos_b_z;
      for (int k = 0; k < 3; k++) begin
        w[k] = wrap_axis(b[k] - a[k], ovf);
        r2 += 64'(w[k] * w[k]);
        f[k] = 0;
      end
      if (r2 == 0) ovf = 1'b1;
      inr = r2 < (64'(cut_sq) << 24);
      if (inr && r2 < (64'd1 << 44)) begin
        ovf = 1'b1;
        energy = longint'(Q48_MAX);
        virial = longint'(Q48_MAX);
        for (int k = 0; k < 3; k++)
          f[k] = (w[k] > 0) ? longint'(Q48_MAX) : ((w[k] < 0) ? longint'(Q48_MIN) : 0);
      end else if (inr) begin
        q = (128'd1 << 64) / {64'd0, r2 >> 16};
        s = q[63:0];
        s2 = mul_q32(s, s);
        s3 = mul_q32(s2, s);
        s4 = mul_q32(s2, s2);
        s6 = mul_q32(s3, s3);
        s7 = mul_q32(s6, s);
        g = 2 * longint'(s7) - longint'(s4);
        energy = ((4 * (longint'(s6) - longint'(s3))) >>> 8) + longint'(e_shift);
        energy = sat48(energy, ovf);
        virial = (24 * (2 * longint'(s6) - longint'(s3))) >>> 8;
        virial = sat48(virial, ovf);
        for (int k = 0; k < 3; k++) f[k] = axis_force(w[k], g, ovf);
      end
      r.force_x = f[0][47:0];
      r.force_y = f[1][47:0];
      r.force_z = f[2][47:0];
      r.pair_energy = energy[47:0];
      r.pair_virial = virial[47:0];
      r.in_range = inr;
      r.overflow = ovf;
      return r;
    endfunction

    function void note_pair(pair_t p);
      res_t r;
      r = pair_force(p);
      pairs_seen++;
      if (r.in_range) hits_in_range++;
      if (r.overflow) hits_overflow++;
      expected_q.push_back(r);
    endfunction

    function void field_diff(string fname, logic [47:0] e, logic [47:0] g, ref bit bad);
      if (e !== g) begin
        bad = 1'b1;
        if (mismatches < 10)
          $display("  %s: expected %h, got %h", fname, e, g);
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      bit   bad;
      bad = 1'b0;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (e !== got && mismatches < 10)
        $display("mismatch on result %0d at %0t", checked, $realtime);
      field_diff("force_x", e.force_x, got.force_x, bad);
      field_diff("force_y", e.force_y, got.force_y, bad);
      field_diff("force_z", e.force_z, got.force_z, bad);
      field_diff("pair_energy", e.pair_energy, got.pair_energy, bad);
      field_diff("pair_virial", e.pair_virial, got.pair_virial, bad);
      field_diff("in_range", 48'(e.in_range), 48'(got.in_range), bad);
      field_diff("overflow", 48'(e.overflow), 48'(got.overflow), bad);
      if (bad) mismatches++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  pair_t       in_pair;
  logic        out_strobe;
  res_t        out_result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  force_scoreboard sb;
  int              idle_pct;
  int              quiet_cycles;

  lj_pair_force_min_image i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pair   (in_pair),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_pair(in_pair);
      if (out_strobe) sb.check_result(out_result);
      if ((cfg_valid && cfg_ready) || (start && !busy) || out_strobe) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic write_cfg(logic [7:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pair(pair_t p);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_pair <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pair_t offset_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                        longint dx, longint dy, longint dz);
    pair_t p;
    p.pos_a_x = ax;
    p.pos_a_y = ay;
    p.pos_a_z = az;
    p.pos_b_x = ax + 32'(dx);
    p.pos_b_y = ay + 32'(dy);
    p.pos_b_z = az + 32'(dz);
    return p;
  endfunction

  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  function automatic pair_t random_pair();
    pair_t  p;
    int     kind;
    longint lim;
    longint shift;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return p;
    end
    lim = (kind < 22) ? ONE_Q24 / 4 : 3 * ONE_Q24;
    p = offset_pair($urandom, $urandom, $urandom,
                    rand_span(lim), rand_span(lim), rand_span(lim));
    if ($urandom_range(0, 3) == 0) begin
      shift = longint'($urandom_range(0, 4)) - 2;
      p.pos_b_x = p.pos_b_x + 32'(shift * longint'(sb.box));
      p.pos_b_z = p.pos_b_z - 32'(shift * longint'(sb.box));
    end
    return p;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_pair(random_pair());
    end_burst();
  endtask

  task automatic run_directed();
    pair_t p;
    // zero distance, overlap, attractive and repulsive pairs, cutoff edge
    send_pair(offset_pair(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
    send_pair(offset_pair(0, 0, 0, ONE_Q24 / 10, 0, 0));
    send_pair(offset_pair(0, 0, 0, -ONE_Q24 / 10, ONE_Q24 / 20, 0));
    send_pair(offset_pair(0, 0, 0, ONE_Q24 / 4, 0, 0));
    send_pair(offset_pair(0, 0, 0, ONE_Q24 / 4 - 1, 0, 0));
    send_pair(offset_pair(0, 0, 0, 0, 0, ONE_Q24 * 112 / 100));
    send_pair(offset_pair(0, 0, 0, -ONE_Q24 * 9 / 10, 0, 0));
    send_pair(offset_pair(0, 0, 0, 0, -2 * ONE_Q24, ONE_Q24));
    send_pair(offset_pair(0, 0, 0, 5 * ONE_Q24 / 2 - 1, 0, 0));
    send_pair(offset_pair(0, 0, 0, 5 * ONE_Q24 / 2, 0, 0));
    send_pair(offset_pair(0, 0, 0, 4 * ONE_Q24, 0, 0));
    // near half box and wrapped neighbors
    send_pair(offset_pair(0, 0, 0, 5 * ONE_Q24, 0, 0));
    send_pair(offset_pair(0, 0, 0, -5 * ONE_Q24, 0, 0));
    send_pair(offset_pair(0, 0, 0, 9 * ONE_Q24, 0, 0));
    send_pair(offset_pair(0, 0, 0, -19 * ONE_Q24 / 2, ONE_Q24 * 201 / 20, 0));
    // field extremes
    p = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_pair(p);
    p = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_pair(p);
    p = {32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
    send_pair(p);
    end_burst();
  endtask

  initial begin
    sb = new();
    quiet_cycles = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_pair = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(280);
    drain();

    // widest box with a tiny inverse, all-reaching cutoff, most negative shift
    write_cfg(REG_BOX, 32'h7FFF_FFFF);
    write_cfg(REG_INV_BOX, 32'd1);
    write_cfg(REG_CUTOFF_SQ, 32'h7FFF_FFFF);
    write_cfg(REG_ENERGY_SHIFT, 32'h8000_0000);
    idle_pct = 62;
    run_directed();
    run_random(260);
    drain();

    // no wrapping at all: wide displacements clamp
    write_cfg(REG_BOX, 32'd0);
    write_cfg(REG_INV_BOX, 32'd0);
    write_cfg(REG_ENERGY_SHIFT, 32'h7FFF_FFFF);
    write_cfg(REG_SPARE, 32'hFFFF_FFFF);
    idle_pct = 0;
    run_directed();
    run_random(260);
    drain();

    // small consistent box, wrap-dominated
    write_cfg(REG_BOX, 32'(4 * ONE_Q24));
    write_cfg(REG_INV_BOX, 32'(ONE_Q24 / 4));
    write_cfg(REG_CUTOFF_SQ, 32'(4 * ONE_Q24));
    write_cfg(REG_ENERGY_SHIFT, 32'd0);
    idle_pct = 31;
    run_directed();
    run_random(260);
    drain();

    // nothing in range
    write_cfg(REG_CUTOFF_SQ, 32'd0);
    write_cfg(REG_INV_BOX, 32'h7FFF_FFFF);
    idle_pct = 0;
    run_random(100);
    drain();

    $display("covered %0d pairs over five register settings, %0d results checked",
             sb.pairs_seen, sb.checked);
    $display("%0d pairs inside the cutoff, %0d flagged overflow, %0d mismatches",
             sb.hits_in_range, sb.hits_overflow, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ljpf_pkg.sv
hw/rtl/lj_pair_force_min_image.sv
hw/rtl/ljpf_chk.sv
tb/sv/tb_lj_pair_force_min_image.sv
